/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, off while reset is held.
`define DWFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DWFE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/dwfe_pkg.sv */
// Types, constants and codes of the display write frame encoder.
package dwfe_pkg;

    localparam int FRAME_BUFFER_BYTES = 64;
    localparam int HDR_BYTES          = 6;
    localparam int TERM_BYTES         = 2;
    localparam int STORE_DEPTH        = FRAME_BUFFER_BYTES - HDR_BYTES;
    localparam int IDX_W              = $clog2(FRAME_BUFFER_BYTES);
    localparam int TOTAL_W            = IDX_W + 1;
    localparam int ADDR_W             = $clog2(STORE_DEPTH);

    localparam logic [7:0] SYNC_HI    = 8'h5A;
    localparam logic [7:0] SYNC_LO    = 8'hA5;
    localparam logic [7:0] OP_WRITE   = 8'h82;
    localparam logic [7:0] PAGE_REG   = 8'h84;
    localparam logic [7:0] LEN_WORD32 = 8'h07;
    localparam logic [7:0] LEN_WORD16 = 8'h05;
    localparam logic [7:0] TERM_BYTE  = 8'hFF;
    localparam logic [7:0] PAGE_MODE  = 8'h01;

    typedef enum logic [1:0] {
        CMD_SET_PAGE = 2'd0,
        CMD_WRITE16  = 2'd1,
        CMD_WRITE32  = 2'd2,
        CMD_STRING   = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        STS_FRAME_BYTE   = 2'd0,
        STS_OVERSIZE     = 2'd1,
        STS_ZERO_LIMIT   = 2'd2,
        STS_NOTHING_SENT = 2'd3
    } t_out_status;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic check;
        logic emit_step;
        logic load_status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_fixed;
        logic in_last;
        logic reject;
        logic frame_end;
        logic out_free;
    } t_dp_sts;

endpackage

/* hw/rtl/dwfe_req_if.sv */
// Request channel: one command item per beat.
interface dwfe_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [15:0]        target_addr;
    logic signed [31:0] value;
    logic [7:0]         text_byte;
    logic               has_byte;
    logic               string_last;
    logic               terminated;
    logic [15:0]        length_limit;

    modport source (
        output valid, command, target_addr, value, text_byte, has_byte,
               string_last, terminated, length_limit,
        input  ready
    );
    modport sink (
        input  valid, command, target_addr, value, text_byte, has_byte,
               string_last, terminated, length_limit,
        output ready
    );
endinterface

/* hw/rtl/dwfe_rsp_if.sv */
// Response channel: one frame byte or status per beat.
interface dwfe_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;
    logic [1:0] status;

    modport source (
        output valid, frame_byte, frame_last, status,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, frame_last, status,
        output ready
    );
endinterface

/* hw/rtl/dwfe_ctrl.sv */
// Sequencer: accepts items, runs the string check and steps frame emission or the status beat.
module dwfe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  dwfe_pkg::t_dp_sts i_sts,
    output dwfe_pkg::t_dp_cmd o_cmd
);
    import dwfe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_EMIT   = 4'b0100,
        S_STATUS = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_req_ready       = (r_state == S_IDLE);
        o_cmd.accept      = (r_state == S_IDLE) && i_req_valid;
        o_cmd.check       = (r_state == S_CHECK);
        o_cmd.emit_step   = (r_state == S_EMIT) && i_sts.out_free;
        o_cmd.load_status = (r_state == S_STATUS) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_sts.in_fixed) begin
                        n_state = S_EMIT;
                    end else if (i_sts.in_last) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_state = i_sts.reject ? S_STATUS : S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free && i_sts.frame_end) begin
                    n_state = S_IDLE;
                end
            end
            S_STATUS: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/dwfe_datapath.sv */
// String state, text store, frame byte selection and the output register.
module dwfe_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_command,
    input  logic [15:0]        i_target_addr,
    input  logic signed [31:0] i_value,
    input  logic [7:0]         i_text_byte,
    input  logic               i_has_byte,
    input  logic               i_string_last,
    input  logic               i_terminated,
    input  logic [15:0]        i_length_limit,
    input  logic               i_out_ready,
    input  dwfe_pkg::t_dp_cmd  i_cmd,
    output dwfe_pkg::t_dp_sts  o_sts,
    output logic               o_out_valid,
    output logic [7:0]         o_frame_byte,
    output logic               o_frame_last,
    output logic [1:0]         o_status
);
    import dwfe_pkg::*;

    // item and string state
    t_command              r_cmd,        n_cmd;
    logic [31:0]           r_value,      n_value;
    logic [15:0]           r_addr,       n_addr;
    logic                  r_open,       n_open;
    logic [15:0]           r_count,      n_count;
    logic [15:0]           r_held_addr,  n_held_addr;
    logic [15:0]           r_held_limit, n_held_limit;
    logic                  r_held_term,  n_held_term;
    // emission
    logic [IDX_W-1:0]      r_idx,        n_idx;
    logic [TOTAL_W-1:0]    r_total,      n_total;
    logic [IDX_W-1:0]      r_kept,       n_kept;
    t_out_status           r_code,       n_code;
    // output register
    logic                  r_out_valid,  n_out_valid;
    logic [7:0]            r_out_byte,   n_out_byte;
    logic                  r_out_last,   n_out_last;
    t_out_status           r_out_status, n_out_status;

    logic [7:0]            r_store [STORE_DEPTH];
    logic [7:0]            r_rd_data;

    logic                  in_string;
    logic [15:0]           base_count;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [IDX_W-1:0]      rd_t;
    logic [ADDR_W-1:0]     rd_addr;
    logic [15:0]           kept_full;
    logic [16:0]           total_full;
    logic                  zero_lim;
    logic                  empty_raw;
    logic                  oversize;
    t_out_status           check_code;
    logic                  frame_end;
    logic                  out_free;
    logic [7:0]            fixed_byte;
    logic [7:0]            string_byte;
    logic [IDX_W-1:0]      text_t;

    assign in_string  = (t_command'(i_command) == CMD_STRING);
    assign base_count = r_open ? r_count : 16'd0;
    assign wr_en      = i_cmd.accept && in_string && i_has_byte
                        && (base_count < 16'(STORE_DEPTH));
    assign wr_addr    = base_count[ADDR_W-1:0];

    // string outcome, from the registered string state
    always_comb begin
        kept_full  = (r_count < r_held_limit) ? r_count : r_held_limit;
        total_full = {1'b0, kept_full}
                     + (r_held_term ? 17'(HDR_BYTES + TERM_BYTES) : 17'(HDR_BYTES));
        zero_lim   = r_held_term && (r_held_limit == 16'd0);
        empty_raw  = !r_held_term && (r_count == 16'd0);
        oversize   = total_full > 17'(FRAME_BUFFER_BYTES);
        if (zero_lim) begin
            check_code = STS_ZERO_LIMIT;
        end else if (empty_raw) begin
            check_code = STS_NOTHING_SENT;
        end else if (oversize) begin
            check_code = STS_OVERSIZE;
        end else begin
            check_code = STS_FRAME_BYTE;
        end
    end

    assign frame_end = ({1'b0, r_idx} == (r_total - TOTAL_W'(1)));
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.in_fixed  = !in_string;
        o_sts.in_last   = i_string_last;
        // judged in the check cycle, before the code is registered
        o_sts.reject    = (check_code != STS_FRAME_BYTE);
        o_sts.frame_end = frame_end;
        o_sts.out_free  = out_free;
    end

    // fixed-command frames
    always_comb begin
        fixed_byte = 8'h00;
        case (r_idx)
            IDX_W'(0): fixed_byte = SYNC_HI;
            IDX_W'(1): fixed_byte = SYNC_LO;
            IDX_W'(2): fixed_byte = (r_cmd == CMD_WRITE16) ? LEN_WORD16 : LEN_WORD32;
            IDX_W'(3): fixed_byte = OP_WRITE;
            IDX_W'(4): fixed_byte = (r_cmd == CMD_SET_PAGE) ? 8'h00 : r_addr[15:8];
            IDX_W'(5): fixed_byte = (r_cmd == CMD_SET_PAGE) ? PAGE_REG : r_addr[7:0];
            IDX_W'(6): begin
                case (r_cmd)
                    CMD_SET_PAGE: fixed_byte = SYNC_HI;
                    CMD_WRITE32:  fixed_byte = r_value[31:24];
                    default:      fixed_byte = r_value[15:8];
                endcase
            end
            IDX_W'(7): begin
                case (r_cmd)
                    CMD_SET_PAGE: fixed_byte = PAGE_MODE;
                    CMD_WRITE32:  fixed_byte = r_value[23:16];
                    default:      fixed_byte = r_value[7:0];
                endcase
            end
            IDX_W'(8): fixed_byte = r_value[15:8];
            IDX_W'(9): fixed_byte = r_value[7:0];
            default:   fixed_byte = 8'h00;
        endcase
    end

    // string frame: header, text from the store, then FF FF when terminated
    always_comb begin
        text_t = r_idx - IDX_W'(HDR_BYTES);
        case (r_idx)
            IDX_W'(0): string_byte = SYNC_HI;
            IDX_W'(1): string_byte = SYNC_LO;
            IDX_W'(2): string_byte = 8'(r_total - TOTAL_W'(3));
            IDX_W'(3): string_byte = OP_WRITE;
            IDX_W'(4): string_byte = r_held_addr[15:8];
            IDX_W'(5): string_byte = r_held_addr[7:0];
            default: begin
                string_byte = (text_t < r_kept) ? r_rd_data : TERM_BYTE;
            end
        endcase
    end

    always_comb begin
        n_cmd        = r_cmd;
        n_value      = r_value;
        n_addr       = r_addr;
        n_open       = r_open;
        n_count      = r_count;
        n_held_addr  = r_held_addr;
        n_held_limit = r_held_limit;
        n_held_term  = r_held_term;
        n_idx        = r_idx;
        n_total      = r_total;
        n_kept       = r_kept;
        n_code       = r_code;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;

        if (i_cmd.accept) begin
            n_cmd   = t_command'(i_command);
            n_value = $unsigned(i_value);
            n_addr  = i_target_addr;
            n_idx   = '0;
            if (!in_string) begin
                n_total = (t_command'(i_command) == CMD_WRITE16)
                          ? TOTAL_W'(8) : TOTAL_W'(10);
            end else begin
                if (!r_open) begin
                    n_open       = 1'b1;
                    n_held_addr  = i_target_addr;
                    n_held_limit = i_length_limit;
                    n_held_term  = i_terminated;
                end
                n_count = base_count;
                if (i_has_byte && (base_count != 16'hFFFF)) begin
                    n_count = base_count + 16'd1;
                end
            end
        end

        if (i_cmd.check) begin
            n_idx   = '0;
            n_total = total_full[TOTAL_W-1:0];
            n_kept  = kept_full[IDX_W-1:0];
            n_code  = check_code;
            n_open  = 1'b0;
            n_count = 16'd0;
        end

        if (i_cmd.emit_step) begin
            n_out_valid  = 1'b1;
            n_out_byte   = (r_cmd == CMD_STRING) ? string_byte : fixed_byte;
            n_out_last   = frame_end;
            n_out_status = STS_FRAME_BYTE;
            n_idx        = r_idx + IDX_W'(1);
        end

        if (i_cmd.load_status) begin
            n_out_valid  = 1'b1;
            n_out_byte   = 8'h00;
            n_out_last   = 1'b1;
            n_out_status = r_code;
        end
    end

    // read one beat ahead: address follows the next byte index
    always_comb begin
        rd_t    = n_idx - IDX_W'(HDR_BYTES);
        rd_addr = '0;
        if ((n_idx >= IDX_W'(HDR_BYTES)) && (rd_t < IDX_W'(STORE_DEPTH))) begin
            rd_addr = rd_t[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= i_text_byte;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open       <= 1'b0;
            r_count      <= 16'd0;
            r_held_addr  <= 16'd0;
            r_held_limit <= 16'd0;
            r_held_term  <= 1'b0;
            r_idx        <= '0;
            r_total      <= '0;
            r_code       <= STS_FRAME_BYTE;
            r_out_valid  <= 1'b0;
        end else begin
            r_open       <= n_open;
            r_count      <= n_count;
            r_held_addr  <= n_held_addr;
            r_held_limit <= n_held_limit;
            r_held_term  <= n_held_term;
            r_idx        <= n_idx;
            r_total      <= n_total;
            r_code       <= n_code;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_value      <= n_value;
        r_addr       <= n_addr;
        r_kept       <= n_kept;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_last = r_out_last;
    assign o_status     = r_out_status;

endmodule

/* hw/rtl/display_write_frame_encoder_unit.sv */
// A fixed command is taken and its bytes then leave at one per cycle while the output
// is free; it makes 8 or 10 bytes, and the next item is taken once its last byte is emitted.
// A string item without string_last is taken while the sequencer stays idle. A last
// string item is checked, then gives a frame of 6..FRAME_BUFFER_BYTES bytes or 1 status beat.
// Output backpressure stalls the sequencer; one finished beat waits in the output register.
// Reset (sync, active low) closes any open string and empties the output; store contents stay undefined.
module display_write_frame_encoder_unit (
    input logic    i_clk,
    input logic    i_rst_n,
    dwfe_req_if.sink   i_req,
    dwfe_rsp_if.source o_rsp
);
    import dwfe_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    req_ready;

    dwfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    dwfe_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (i_req.command),
        .i_target_addr  (i_req.target_addr),
        .i_value        (i_req.value),
        .i_text_byte    (i_req.text_byte),
        .i_has_byte     (i_req.has_byte),
        .i_string_last  (i_req.string_last),
        .i_terminated   (i_req.terminated),
        .i_length_limit (i_req.length_limit),
        .i_out_ready    (o_rsp.ready),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .o_out_valid    (o_rsp.valid),
        .o_frame_byte   (o_rsp.frame_byte),
        .o_frame_last   (o_rsp.frame_last),
        .o_status       (o_rsp.status)
    );

    assign i_req.ready = req_ready;

endmodule

/* hw/rtl/dwfe_checker.sv */
// Port-level checks of the frame encoder, bound to the top level.
`include "assert_macros.svh"

module dwfe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic [1:0] i_req_command,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [7:0] i_rsp_frame_byte,
    input logic       i_rsp_frame_last,
    input logic [1:0] i_rsp_status
);
    import dwfe_pkg::*;

    logic        fixed_take;
    logic        mid_beat;
    logic        rsp_stall;
    logic [10:0] rsp_beat;

    assign fixed_take = i_req_valid && i_req_ready && (i_req_command != CMD_STRING);
    assign mid_beat   = i_rsp_valid && !i_rsp_frame_last;
    assign rsp_stall  = i_rsp_valid && !i_rsp_ready;
    assign rsp_beat   = {i_rsp_frame_byte, i_rsp_frame_last, i_rsp_status};

    // output is empty right after reset
    `DWFE_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !i_rsp_valid, "output valid after reset")

    // a fixed command starts emission, so no new item the next cycle
    `DWFE_ASSERT(a_fixed_busy, fixed_take |=> !i_req_ready, "item taken during a fixed frame")

    // a non-final beat means the frame is still running
    `DWFE_ASSERT(a_mid_frame_busy, mid_beat |-> !i_req_ready, "item taken mid frame")

    // a stalled beat holds
    `DWFE_ASSERT(a_rsp_hold, rsp_stall |=> (i_rsp_valid && $stable(rsp_beat)), "stalled beat changed")

endmodule

bind display_write_frame_encoder_unit dwfe_checker u_dwfe_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_req_command    (i_req.command),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_frame_byte (o_rsp.frame_byte),
    .i_rsp_frame_last (o_rsp.frame_last),
    .i_rsp_status     (o_rsp.status)
);
